@@ hw/rtl/pot_pkg.sv @@
// Shared types, constants and arithmetic helpers of the oriented triangle core.
`timescale 1ns / 1ps
`default_nettype none
package pot_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int UNIT_SHIFT = 30;
    localparam int UP_SHIFT   = UNIT_SHIFT - FRAC_BITS;

    // Squared length floor for a degenerate normal or camera vector, in LSB^2
    localparam longint unsigned DEG2 =
        ((64'd1 << (2 * FRAC_BITS)) + 64'd999999999999) / 64'd1000000000000;
    localparam logic [23:0] DEG2_LIM  = 24'(DEG2);
    localparam logic [23:0] UDEG2_LIM = 24'd1152922;
    // Magnitudes at or above 2^bits already square past the limit
    localparam int DEG_BITS  = 9;
    localparam int UDEG_BITS = 11;

    localparam longint RAD_MIN_RAW = ((longint'(1) << FRAC_BITS) + 5000) / 10000;
    localparam logic [31:0] RAD_MIN = (RAD_MIN_RAW > 0) ? 32'(RAD_MIN_RAW) : 32'd1;

    localparam logic [32:0]        Z_LIMIT  = 33'd966367641;
    localparam logic signed [63:0] SIN120   = 64'sd929887697;
    localparam logic signed [63:0] W_LIMIT  = 64'sd2147483648;
    localparam logic [63:0]        HALF_MAG = 64'd1 << (UNIT_SHIFT - 1);

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        CFG_ORIENT_MODE = 2'd0,
        CFG_CAM_X       = 2'd1,
        CFG_CAM_Y       = 2'd2,
        CFG_CAM_Z       = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0][31:0] p;
        logic [31:0]      rad;
        logic             fb;
    } t_side;

    typedef struct packed {
        t_side            side;
        logic [2:0][32:0] vec;
        logic             byp;
    } t_task;

    typedef struct packed {
        t_side            side;
        logic [2:0][31:0] d;
    } t_mid;

    function automatic logic [32:0] ext33(input logic [31:0] x);
        return {x[31], x};
    endfunction

    function automatic logic [32:0] neg33(input logic [31:0] x);
        logic [32:0] e;
        e = {x[31], x};
        return 33'(-e);
    endfunction

    function automatic logic [32:0] mag33(input logic [31:0] x);
        logic [32:0] e;
        e = {x[31], x};
        return x[31] ? 33'(-e) : e;
    endfunction

    function automatic logic [5:0] msb33(input logic [32:0] x);
        logic [5:0] r;
        r = '0;
        for (int k = 0; k < 33; k++) begin
            if (x[k]) r = 6'(k);
        end
        return r;
    endfunction

    // Exact short-vector test: every magnitude below 2^bits and squared length below lim
    function automatic logic is_short(input logic [2:0][32:0] v, input int bits,
                                      input logic [23:0] lim);
        logic        ok;
        logic [32:0] m;
        logic [10:0] lo;
        logic [23:0] s;
        ok = 1'b1;
        s  = '0;
        for (int k = 0; k < 3; k++) begin
            m = v[k][32] ? 33'(-v[k]) : v[k];
            if (m >= (33'd1 << bits)) ok = 1'b0;
            lo = m[10:0];
            s  = s + 24'(lo) * 24'(lo);
        end
        return ok && (s < lim);
    endfunction

    // Drop 30 fraction bits, round half away from zero
    function automatic logic signed [63:0] rs30(input logic signed [63:0] x);
        logic [63:0] m;
        m = x[63] ? 64'(-x) : 64'(x);
        m = (m + HALF_MAG) >> UNIT_SHIFT;
        return x[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    function automatic logic [32:0] clampw(input logic signed [63:0] x);
        if (x > W_LIMIT) return W_LIMIT[32:0];
        if (x < -W_LIMIT) return 33'(-W_LIMIT);
        return x[32:0];
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/point_to_oriented_triangle_core.sv @@
// Top level: one oriented equilateral triangle per point, fully pipelined.
// Usage:
//   Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data):
//   index 0 orientation mode, 1..3 camera centre x/y/z in Q16.16. Write it
//   only while no request is in flight.
//   Input requests (point, radius, normal) are taken when i_valid is high and
//   o_stall is low. Results (three corners and the camera fallback flag) are
//   offered on o_valid and taken when i_stall is low.
//   Throughput: one request per cycle while o_stall and i_stall are low. The
//   path from acceptance to o_valid runs through capture, queue, the two
//   normalisers (69 stages each: a 31-stage square root and a 31-stage
//   divider), cross product and corner stages.
//   Reset (i_rst_n low, synchronous) clears the configuration to zero and
//   empties the pipeline and the four-entry request queue.
//   When the receiver stalls, the back end holds in place; the queue then
//   fills and o_stall rises once the queue and the capture register are full.
`timescale 1ns / 1ps
`default_nettype none
module point_to_oriented_triangle_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_point_x,
    input  wire logic [31:0] i_point_y,
    input  wire logic [31:0] i_point_z,
    input  wire logic [31:0] i_radius,
    input  wire logic [31:0] i_normal_x,
    input  wire logic [31:0] i_normal_y,
    input  wire logic [31:0] i_normal_z,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_corner0_x,
    output logic [31:0]      o_corner0_y,
    output logic [31:0]      o_corner0_z,
    output logic [31:0]      o_corner1_x,
    output logic [31:0]      o_corner1_y,
    output logic [31:0]      o_corner1_z,
    output logic [31:0]      o_corner2_x,
    output logic [31:0]      o_corner2_y,
    output logic [31:0]      o_corner2_z,
    output logic             o_used_camera_fallback
);
    import pot_pkg::*;

    logic                  push;
    logic                  full;
    t_task                 f_task;
    logic                  q_valid;
    t_task                 q_task;
    logic                  pop;
    logic [2:0][2:0][31:0] corner;

    pot_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_point     ({i_point_z, i_point_y, i_point_x}),
        .i_radius    (i_radius),
        .i_normal    ({i_normal_z, i_normal_y, i_normal_x}),
        .i_full      (full),
        .o_push      (push),
        .o_task      (f_task)
    );

    pot_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_task),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_task),
        .i_pop   (pop)
    );

    pot_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (q_valid),
        .i_task       (q_task),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_corner     (corner),
        .o_fb         (o_used_camera_fallback)
    );

    assign o_corner0_x = corner[0][0];
    assign o_corner0_y = corner[0][1];
    assign o_corner0_z = corner[0][2];
    assign o_corner1_x = corner[1][0];
    assign o_corner1_y = corner[1][1];
    assign o_corner1_z = corner[1][2];
    assign o_corner2_x = corner[2][0];
    assign o_corner2_y = corner[2][1];
    assign o_corner2_z = corner[2][2];

endmodule
`default_nettype wire

@@ hw/rtl/pot_norm.sv @@
// Pipelined vector normaliser: scale, square-sum, bit-serial square root and divide.
`timescale 1ns / 1ps
`default_nettype none
module pot_norm #(
    parameter int SB_W = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [2:0][32:0] i_vec,
    input  wire logic             i_byp,
    input  wire logic [SB_W-1:0]  i_sb,
    output logic                  o_valid,
    output logic [2:0][31:0]      o_vec,
    output logic [SB_W-1:0]       o_sb
);
    import pot_pkg::*;

    localparam int SQ_N  = 31;
    localparam int DIV_N = 31;
    localparam int LAT   = 7 + SQ_N + DIV_N;

    typedef struct packed {
        logic [SB_W-1:0]  sb;
        logic             byp;
        logic             zero;
        logic [2:0]       neg;
        logic [2:0][31:0] raw;
    } t_tag;

    logic             r_vld [LAT];
    t_tag             r_tag [LAT];
    t_tag             a_tag;
    logic [2:0][32:0] a_mag;
    logic [32:0]      a_mx;

    logic [2:0][32:0] r_a_mag;
    logic [32:0]      r_a_mx;
    logic [2:0][32:0] r_b_mag;
    logic [5:0]       r_b_msb;
    logic [2:0][29:0] c_m;
    logic [2:0][29:0] r_c_m;
    logic [2:0][29:0] r_d_m;
    logic [2:0][59:0] r_d_sq;

    logic [61:0]      r_rem  [SQ_N+1];
    logic [30:0]      r_root [SQ_N+1];
    logic [2:0][29:0] r_sm   [SQ_N+1];

    logic [2:0][59:0] r_qr   [DIV_N+1];
    logic [2:0][30:0] r_qq   [DIV_N+1];
    logic [30:0]      r_qlen [DIV_N+1];

    logic [2:0][31:0] r_g_vec;

    always_comb begin
        a_mx = '0;
        for (int i = 0; i < 3; i++) begin
            a_mag[i] = i_vec[i][32] ? 33'(-i_vec[i]) : i_vec[i];
            if (a_mag[i] > a_mx) a_mx = a_mag[i];
        end
        a_tag.sb   = i_sb;
        a_tag.byp  = i_byp;
        a_tag.zero = (a_mx == '0);
        for (int i = 0; i < 3; i++) begin
            a_tag.neg[i] = i_vec[i][32];
            a_tag.raw[i] = i_vec[i][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= a_tag;
            for (int k = 1; k < LAT; k++) r_tag[k] <= r_tag[k-1];
        end
    end

    // Shift so that the largest magnitude lands in [2^29, 2^30)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_b_msb >= 6'd29) c_m[i] = 30'(r_b_mag[i] >> (r_b_msb - 6'd29));
            else c_m[i] = 30'(r_b_mag[i] << (6'd29 - r_b_msb));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag <= a_mag;
            r_a_mx  <= a_mx;
            r_b_mag <= r_a_mag;
            r_b_msb <= msb33(r_a_mx);
            r_c_m   <= c_m;
            r_d_m   <= r_c_m;
            for (int i = 0; i < 3; i++) r_d_sq[i] <= 60'(r_c_m[i]) * 60'(r_c_m[i]);
            r_rem[0]  <= 62'(r_d_sq[0]) + 62'(r_d_sq[1]) + 62'(r_d_sq[2]);
            r_root[0] <= '0;
            r_sm[0]   <= r_d_m;
        end
    end

    // Square root, one result bit per stage
    for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
        localparam int B = SQ_N - 1 - j;
        logic [63:0] cand;
        logic        take;
        assign cand = (64'(r_root[j]) << (B + 1)) + (64'd1 << (2 * B));
        assign take = 64'(r_rem[j]) >= cand;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= take ? r_rem[j] - cand[61:0] : r_rem[j];
                r_root[j+1] <= take ? (r_root[j] | (31'd1 << B)) : r_root[j];
                r_sm[j+1]   <= r_sm[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_qr[0][i] <= {r_sm[SQ_N][i], 30'b0} + 60'(r_root[SQ_N] >> 1);
            end
            r_qq[0]   <= '0;
            r_qlen[0] <= r_root[SQ_N];
        end
    end

    // Restoring division, one quotient bit per stage, three lanes
    for (genvar j = 0; j < DIV_N; j++) begin : g_div
        localparam int B = DIV_N - 1 - j;
        logic [63:0] dv;
        logic [2:0]  take;
        assign dv = 64'(r_qlen[j]) << B;
        always_comb begin
            for (int i = 0; i < 3; i++) take[i] = 64'(r_qr[j][i]) >= dv;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_qr[j+1][i] <= take[i] ? r_qr[j][i] - dv[59:0] : r_qr[j][i];
                    r_qq[j+1][i] <= take[i] ? (r_qq[j][i] | (31'd1 << B)) : r_qq[j][i];
                end
                r_qlen[j+1] <= r_qlen[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_tag[LAT-2].zero) r_g_vec[i] <= '0;
                else if (r_tag[LAT-2].byp) r_g_vec[i] <= r_tag[LAT-2].raw[i];
                else if (r_tag[LAT-2].neg[i]) r_g_vec[i] <= 32'(-{1'b0, r_qq[DIV_N][i]});
                else r_g_vec[i] <= {1'b0, r_qq[DIV_N][i]};
            end
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_vec   = r_g_vec;
    assign o_sb    = r_tag[LAT-1].sb;

endmodule
`default_nettype wire

@@ hw/rtl/pot_front.sv @@
// Front end: configuration registers, request capture and direction source selection.
`timescale 1ns / 1ps
`default_nettype none
module pot_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [2:0][31:0] i_point,
    input  wire logic [31:0]   i_radius,
    input  wire logic [2:0][31:0] i_normal,
    input  wire logic          i_full,
    output logic               o_push,
    output pot_pkg::t_task     o_task
);
    import pot_pkg::*;

    logic             r_mode;
    logic [2:0][31:0] r_cam;
    logic             r_valid;
    logic [2:0][31:0] r_p;
    logic [31:0]      r_rad;
    logic [2:0][31:0] r_nrm;
    logic [2:0][32:0] r_diff;

    logic [2:0][32:0] nrm33;
    logic [2:0][32:0] up_diff;
    logic             use_nrm;
    logic             diff_short;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_cam  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ORIENT_MODE: r_mode   <= i_cfg_data[0];
                CFG_CAM_X:       r_cam[0] <= i_cfg_data;
                CFG_CAM_Y:       r_cam[1] <= i_cfg_data;
                CFG_CAM_Z:       r_cam[2] <= i_cfg_data;
            endcase
        end
    end

    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_p   <= i_point;
            r_nrm <= i_normal;
            r_rad <= ($signed(i_radius) < $signed(RAD_MIN)) ? RAD_MIN : i_radius;
            for (int i = 0; i < 3; i++) r_diff[i] <= ext33(r_cam[i]) - ext33(i_point[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nrm33[i]   = ext33(r_nrm[i]);
            up_diff[i] = r_diff[i] << UP_SHIFT;
        end
        use_nrm    = !r_mode && !is_short(nrm33, DEG_BITS, DEG2_LIM);
        diff_short = is_short(r_diff, DEG_BITS, DEG2_LIM);
        o_task.side.p   = r_p;
        o_task.side.rad = r_rad;
        o_task.side.fb  = !use_nrm;
        o_task.byp      = !use_nrm && diff_short;
        // A point sitting on the camera keeps its raw offset, moved to unit scale
        if (use_nrm) o_task.vec = nrm33;
        else if (diff_short) o_task.vec = up_diff;
        else o_task.vec = r_diff;
    end

endmodule
`default_nettype wire

@@ hw/rtl/pot_queue.sv @@
// Short request queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none
module pot_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pot_pkg::t_task i_data,
    output logic                o_full,
    output logic                o_valid,
    output pot_pkg::t_task      o_data,
    input  wire logic           i_pop
);
    import pot_pkg::*;

    t_task           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop) r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

endmodule
`default_nettype wire

@@ hw/rtl/pot_back.sv @@
// Back end: direction and tangent normalisation, cross product and corner placement.
`timescale 1ns / 1ps
`default_nettype none
module pot_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_task_valid,
    input  wire pot_pkg::t_task    i_task,
    output logic                   o_pop,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output logic [2:0][2:0][31:0]  o_corner,
    output logic                   o_fb
);
    import pot_pkg::*;

    logic             en;
    logic             n1_valid;
    logic [2:0][31:0] n1_vec;
    t_side            n1_side;
    logic             n2_valid;
    logic [2:0][31:0] n2_vec;
    t_mid             n2_mid;

    logic [2:0][32:0] u;
    logic             r_u_valid;
    logic [2:0][32:0] r_u_vec;
    logic             r_u_byp;
    t_mid             r_u_mid;

    logic             r_v1_valid;
    logic [5:0][63:0] r_v1_pr;
    logic [2:0][31:0] r_v1_un;
    t_side            r_v1_side;

    logic             r_v2_valid;
    logic [2:0][32:0] r_v2_v;
    logic [2:0][31:0] r_v2_un;
    t_side            r_v2_side;

    logic             r_w1_valid;
    logic [2:0][63:0] r_w1_sv;
    logic [2:0][31:0] r_w1_un;
    t_side            r_w1_side;

    logic             r_w2_valid;
    logic [2:0][2:0][32:0] r_w2_w;
    t_side            r_w2_side;

    logic             r_c1_valid;
    logic [2:0][2:0][63:0] r_c1_pr;
    t_side            r_c1_side;

    logic             r_out_valid;
    logic [2:0][2:0][31:0] r_out;
    logic             r_out_fb;

    // Hold the whole pipe while the result waits
    assign en    = !(r_out_valid && i_stall);
    assign o_pop = en && i_task_valid;

    pot_norm #(.SB_W($bits(t_side))) u_norm_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (o_pop),
        .i_vec   (i_task.vec),
        .i_byp   (i_task.byp),
        .i_sb    (i_task.side),
        .o_valid (n1_valid),
        .o_vec   (n1_vec),
        .o_sb    (n1_side)
    );

    // Tangent from the z axis, or the x axis when the direction is close to z
    always_comb begin
        if (mag33(n1_vec[2]) > Z_LIMIT) begin
            u[0] = '0;
            u[1] = ext33(n1_vec[2]);
            u[2] = neg33(n1_vec[1]);
        end else begin
            u[0] = ext33(n1_vec[1]);
            u[1] = neg33(n1_vec[0]);
            u[2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_valid   <= 1'b0;
            r_v1_valid  <= 1'b0;
            r_v2_valid  <= 1'b0;
            r_w1_valid  <= 1'b0;
            r_w2_valid  <= 1'b0;
            r_c1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_u_valid   <= n1_valid;
            r_v1_valid  <= n2_valid;
            r_v2_valid  <= r_v1_valid;
            r_w1_valid  <= r_v2_valid;
            r_w2_valid  <= r_w1_valid;
            r_c1_valid  <= r_w2_valid;
            r_out_valid <= r_c1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u_vec      <= u;
            r_u_byp      <= is_short(u, UDEG_BITS, UDEG2_LIM);
            r_u_mid.side <= n1_side;
            r_u_mid.d    <= n1_vec;
        end
    end

    pot_norm #(.SB_W($bits(t_mid))) u_norm_tan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_u_valid),
        .i_vec   (r_u_vec),
        .i_byp   (r_u_byp),
        .i_sb    (r_u_mid),
        .o_valid (n2_valid),
        .o_vec   (n2_vec),
        .o_sb    (n2_mid)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v1_pr[0] <= $signed(n2_mid.d[1]) * $signed(n2_vec[2]);
            r_v1_pr[1] <= $signed(n2_mid.d[2]) * $signed(n2_vec[1]);
            r_v1_pr[2] <= $signed(n2_mid.d[2]) * $signed(n2_vec[0]);
            r_v1_pr[3] <= $signed(n2_mid.d[0]) * $signed(n2_vec[2]);
            r_v1_pr[4] <= $signed(n2_mid.d[0]) * $signed(n2_vec[1]);
            r_v1_pr[5] <= $signed(n2_mid.d[1]) * $signed(n2_vec[0]);
            r_v1_un    <= n2_vec;
            r_v1_side  <= n2_mid.side;

            for (int i = 0; i < 3; i++) begin
                r_v2_v[i] <= 33'(rs30($signed(r_v1_pr[2*i]) - $signed(r_v1_pr[2*i+1])));
            end
            r_v2_un   <= r_v1_un;
            r_v2_side <= r_v1_side;

            for (int i = 0; i < 3; i++) r_w1_sv[i] <= SIN120 * $signed(r_v2_v[i]);
            r_w1_un   <= r_v2_un;
            r_w1_side <= r_v2_side;

            for (int i = 0; i < 3; i++) begin
                r_w2_w[0][i] <= ext33(r_w1_un[i]);
                r_w2_w[1][i] <= clampw(rs30(-(64'($signed(r_w1_un[i])) <<< 29)
                                            + $signed(r_w1_sv[i])));
                r_w2_w[2][i] <= clampw(rs30(-(64'($signed(r_w1_un[i])) <<< 29)
                                            - $signed(r_w1_sv[i])));
            end
            r_w2_side <= r_w1_side;

            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_c1_pr[k][i] <= $signed(r_w2_side.rad) * $signed(r_w2_w[k][i]);
                end
            end
            r_c1_side <= r_w2_side;

            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_out[k][i] <= sat32(64'($signed(r_c1_side.p[i]))
                                         + rs30($signed(r_c1_pr[k][i])));
                end
            end
            r_out_fb <= r_c1_side.fb;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_corner = r_out;
    assign o_fb     = r_out_fb;

endmodule
`default_nettype wire
